[rtl/bcg_pkg.sv]
// Shared types, constants and discharge curve tables for the battery charge gauge.
package bcg_pkg;

  localparam int REG_W   = 14;
  localparam int NUM_W   = 25;
  localparam int QUO_W   = 11;
  localparam int STEP_W  = 4;
  localparam int PCT_W   = 7;
  localparam int IDX_W   = 4;
  localparam int CURVE_POINTS = 11;

  localparam logic [1:0] REG_EMPTY_MV = 2'd0;
  localparam logic [1:0] REG_FULL_MV  = 2'd1;

  localparam logic [REG_W-1:0] EMPTY_MV_RST    = 14'd6600;
  localparam logic [REG_W-1:0] FULL_MV_RST     = 14'd8350;
  localparam logic [REG_W-1:0] CURVE_BOTTOM_MV = 14'd6600;
  localparam logic [REG_W:0]   MIN_SPAN_MV     = 15'd100;
  localparam logic [QUO_W-1:0] SCALE_K         = 11'd1750;

  localparam logic [STEP_W-1:0] SCALE_STEPS = 4'd11;
  localparam logic [STEP_W-1:0] PCT_STEPS   = 4'd4;

  localparam logic [PCT_W-1:0] PCT_FULL   = 7'd100;
  localparam logic [PCT_W-1:0] PCT_EMPTY  = 7'd0;
  localparam logic [PCT_W-1:0] LOW_ENTER  = 7'd10;
  localparam logic [PCT_W-1:0] LOW_EXIT   = 7'd12;

  localparam logic [REG_W-1:0] CURVE_MV [CURVE_POINTS] = '{
    14'd8350, 14'd8200, 14'd8050, 14'd7900, 14'd7750, 14'd7600,
    14'd7450, 14'd7300, 14'd7100, 14'd6900, 14'd6600
  };
  localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
    7'd100, 7'd95, 7'd85, 7'd75, 7'd62, 7'd50, 7'd38, 7'd24, 7'd10, 7'd3, 7'd0
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_SCALE,
    ST_SEG,
    ST_DIV_PCT,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctl_t;

endpackage

[rtl/bcg_div.sv]
// Restoring divider producing one quotient bit per cycle.
module bcg_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bcg_pkg::div_ctl_t            ctl,
  input  logic [bcg_pkg::NUM_W-1:0]    numerator,
  input  logic [bcg_pkg::REG_W-1:0]    divisor,
  output logic                         done,
  output logic [bcg_pkg::QUO_W-1:0]    quotient
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [bcg_pkg::STEP_W-1:0]    cnt_r, cnt_nxt;
  logic [bcg_pkg::NUM_W-1:0]     rem_r, rem_nxt;
  logic [bcg_pkg::NUM_W-1:0]     dsh_r, dsh_nxt;
  logic [bcg_pkg::QUO_W-1:0]     quo_r, quo_nxt;
  logic                          fits;

  assign fits = (rem_r >= dsh_r);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quo_nxt  = quo_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = ctl.steps - 4'd1;
      rem_nxt  = numerator;
      dsh_nxt  = bcg_pkg::NUM_W'(divisor) << (ctl.steps - 4'd1);
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = fits ? (rem_r - dsh_r) : rem_r;
      quo_nxt = {quo_r[bcg_pkg::QUO_W-2:0], fits};
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = cnt_r - 4'd1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[rtl/battery_charge_gauge_core.sv]
// Battery state of charge gauge: top level with sequencer, scaling and low flag.
//
// Usage: one request on in_* carries a voltage sample in millivolts; one
// result on out_* carries the charge percent and the debounced low flag.
// cfg_* writes the calibration window: index 0 empty_mv, index 1 full_mv;
// other indexes are dropped. cfg_ready is always high; write only when idle.
// A sample at or beyond the window or with a narrow window goes straight
// to the finish state; otherwise the work runs a bit-serial scaling multiply,
// the shared serial divider for the window rescale, a segment lookup, the
// same divider for the rounded interpolation, and a finish state.
// One request is in work at a time; the next is accepted once the previous
// result sits in the output register. A stalled receiver delays work
// only when a second result is ready to leave.
// Reset restores empty_mv 6600 and full_mv 8350, clears the low run count
// and the low flag, and drops any request in work.
// While out_ready is low the result holds on the outputs and the low state
// advances only when that result is loaded.
module battery_charge_gauge_core #(
  parameter int VOLT_BITS   = 14,
  parameter int LOW_SAMPLES = 3
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [VOLT_BITS-1:0]              in_voltage_mv,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bcg_pkg::PCT_W-1:0]         out_charge_percent,
  output logic                              out_battery_low,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [bcg_pkg::REG_W-1:0]         cfg_data
);

  localparam int VW = (VOLT_BITS > bcg_pkg::REG_W) ? VOLT_BITS : bcg_pkg::REG_W;
  localparam logic [1:0] LOW_MAX = 2'(LOW_SAMPLES);

  bcg_pkg::state_t state_r, state_nxt;

  logic [bcg_pkg::REG_W-1:0]  empty_r, full_r;
  logic [1:0]                 run_r, run_nxt;
  logic                       lat_r, lat_nxt;
  logic                       out_valid_r;
  logic [bcg_pkg::PCT_W-1:0]  out_pct_r;
  logic                       out_low_r;

  logic [bcg_pkg::REG_W-1:0]  d_r, d_nxt;
  logic [bcg_pkg::REG_W-1:0]  span_r, span_nxt;
  logic [bcg_pkg::NUM_W-1:0]  acc_r, acc_nxt;
  logic [3:0]                 cnt_r, cnt_nxt;
  logic [bcg_pkg::REG_W-1:0]  c_r, c_nxt;
  logic [bcg_pkg::PCT_W-1:0]  lo_pct_r, lo_pct_nxt;
  logic [bcg_pkg::PCT_W-1:0]  pct_r, pct_nxt;
  logic                       trivial_full, trivial_zero;

  logic                       in_fire, load_out;
  logic [VW-1:0]              v_ext, full_ext, empty_ext;
  logic [bcg_pkg::NUM_W-1:0]  mul_sum;

  logic [bcg_pkg::IDX_W-1:0]  seg_idx;
  logic [bcg_pkg::REG_W-1:0]  seg_lo_mv, seg_hi_mv;
  logic [9:0]                 seg_len;
  logic [8:0]                 seg_off;
  logic [3:0]                 seg_dp;
  logic [12:0]                seg_prod;
  logic [14:0]                seg_num;

  bcg_pkg::div_ctl_t          div_ctl;
  logic [bcg_pkg::NUM_W-1:0]  div_num;
  logic [bcg_pkg::REG_W-1:0]  div_den;
  logic                       div_done;
  logic [bcg_pkg::QUO_W-1:0]  div_quo;
  logic [bcg_pkg::PCT_W-1:0]  pct_sum;

  bcg_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (div_ctl),
    .numerator (div_num),
    .divisor   (div_den),
    .done      (div_done),
    .quotient  (div_quo)
  );

  assign in_fire  = in_valid && in_ready;
  assign load_out = (state_r == bcg_pkg::ST_FIN) && (!out_valid_r || out_ready);

  assign v_ext     = VW'(in_voltage_mv);
  assign full_ext  = VW'(full_r);
  assign empty_ext = VW'(empty_r);
  assign trivial_full = (v_ext >= full_ext);
  assign trivial_zero = (v_ext <= empty_ext) ||
                        ({1'b0, full_r} <= ({1'b0, empty_r} + bcg_pkg::MIN_SPAN_MV));

  assign mul_sum = {acc_r[bcg_pkg::NUM_W-2:0], 1'b0} +
                   (bcg_pkg::SCALE_K[cnt_r] ? bcg_pkg::NUM_W'(d_r) : '0);

  always_comb begin
    seg_idx = 4'(bcg_pkg::CURVE_POINTS - 2);
    for (int i = bcg_pkg::CURVE_POINTS - 2; i >= 0; i--) begin
      if (c_r >= bcg_pkg::CURVE_MV[i+1]) seg_idx = 4'(i);
    end
  end

  always_comb begin
    seg_lo_mv = bcg_pkg::CURVE_MV[seg_idx + 4'd1];
    seg_hi_mv = bcg_pkg::CURVE_MV[seg_idx];
    seg_len   = 10'(seg_hi_mv - seg_lo_mv);
    seg_off   = 9'(c_r - seg_lo_mv);
    seg_dp    = 4'(bcg_pkg::CURVE_PCT[seg_idx] - bcg_pkg::CURVE_PCT[seg_idx + 4'd1]);
    seg_prod  = 13'(seg_off) * 13'(seg_dp);
    seg_num   = {1'b0, seg_prod, 1'b0} + 15'(seg_len);
  end

  assign pct_sum = lo_pct_r + 7'(div_quo[3:0]);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bcg_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (trivial_full || trivial_zero) ? bcg_pkg::ST_FIN : bcg_pkg::ST_MUL;
        end
      end
      bcg_pkg::ST_MUL: begin
        if (cnt_r == 4'd0) state_nxt = bcg_pkg::ST_DIV_SCALE;
      end
      bcg_pkg::ST_DIV_SCALE: begin
        if (div_done) state_nxt = bcg_pkg::ST_SEG;
      end
      bcg_pkg::ST_SEG: begin
        state_nxt = bcg_pkg::ST_DIV_PCT;
      end
      bcg_pkg::ST_DIV_PCT: begin
        if (div_done) state_nxt = bcg_pkg::ST_FIN;
      end
      bcg_pkg::ST_FIN: begin
        if (load_out) state_nxt = bcg_pkg::ST_IDLE;
      end
      default: state_nxt = bcg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state_r == bcg_pkg::ST_IDLE);
    cfg_ready     = 1'b1;
    div_ctl.start = 1'b0;
    div_ctl.steps = bcg_pkg::SCALE_STEPS;
    div_num       = mul_sum;
    div_den       = span_r;
    unique case (state_r)
      bcg_pkg::ST_MUL: begin
        div_ctl.start = (cnt_r == 4'd0);
      end
      bcg_pkg::ST_SEG: begin
        div_ctl.start = 1'b1;
        div_ctl.steps = bcg_pkg::PCT_STEPS;
        div_num       = bcg_pkg::NUM_W'(seg_num);
        div_den       = bcg_pkg::REG_W'({seg_len, 1'b0});
      end
      default: ;
    endcase
  end

  always_comb begin
    d_nxt      = d_r;
    span_nxt   = span_r;
    acc_nxt    = acc_r;
    cnt_nxt    = cnt_r;
    c_nxt      = c_r;
    lo_pct_nxt = lo_pct_r;
    pct_nxt    = pct_r;
    case (state_r)
      bcg_pkg::ST_IDLE: begin
        if (in_fire) begin
          d_nxt    = bcg_pkg::REG_W'(v_ext - empty_ext);
          span_nxt = full_r - empty_r;
          acc_nxt  = '0;
          cnt_nxt  = 4'(bcg_pkg::QUO_W - 1);
          pct_nxt  = trivial_full ? bcg_pkg::PCT_FULL : bcg_pkg::PCT_EMPTY;
        end
      end
      bcg_pkg::ST_MUL: begin
        acc_nxt = mul_sum;
        cnt_nxt = cnt_r - 4'd1;
      end
      bcg_pkg::ST_DIV_SCALE: begin
        if (div_done) c_nxt = bcg_pkg::CURVE_BOTTOM_MV + bcg_pkg::REG_W'(div_quo);
      end
      bcg_pkg::ST_SEG: begin
        lo_pct_nxt = bcg_pkg::CURVE_PCT[seg_idx + 4'd1];
      end
      bcg_pkg::ST_DIV_PCT: begin
        if (div_done) begin
          pct_nxt = (pct_sum > bcg_pkg::PCT_FULL) ? bcg_pkg::PCT_FULL : pct_sum;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    run_nxt = run_r;
    lat_nxt = lat_r;
    if (pct_r < bcg_pkg::LOW_ENTER) begin
      if (run_r < LOW_MAX) run_nxt = run_r + 2'd1;
    end else begin
      run_nxt = 2'd0;
    end
    if (!lat_r && (run_nxt >= LOW_MAX)) begin
      lat_nxt = 1'b1;
    end else if (lat_r && (pct_r >= bcg_pkg::LOW_EXIT)) begin
      lat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bcg_pkg::ST_IDLE;
      empty_r     <= bcg_pkg::EMPTY_MV_RST;
      full_r      <= bcg_pkg::FULL_MV_RST;
      run_r       <= 2'd0;
      lat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          bcg_pkg::REG_EMPTY_MV: empty_r <= cfg_data;
          bcg_pkg::REG_FULL_MV:  full_r  <= cfg_data;
          default: ;
        endcase
      end
      if (load_out) begin
        run_r       <= run_nxt;
        lat_r       <= lat_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    d_r      <= d_nxt;
    span_r   <= span_nxt;
    acc_r    <= acc_nxt;
    cnt_r    <= cnt_nxt;
    c_r      <= c_nxt;
    lo_pct_r <= lo_pct_nxt;
    pct_r    <= pct_nxt;
    if (load_out) begin
      out_pct_r <= pct_r;
      out_low_r <= lat_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_charge_percent = out_pct_r;
  assign out_battery_low    = out_low_r;

endmodule
